### sv/dvrt_pkg.sv
// ---------------------------------------------------------------------------
// dvrt_pkg: shared types and constants of the distance-vector route table
// Item structs, configuration indexes, item kinds and control structs.
// ---------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned NodeCount = 15;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned CostW     = 8;
  localparam int unsigned Depth     = 16;

  localparam logic [2:0] CfgMyAddr   = 3'd0;
  localparam logic [2:0] CfgLinkCost = 3'd1;
  localparam logic [2:0] CfgMaxCost  = 3'd2;
  localparam logic [2:0] CfgInfCost  = 3'd3;
  localparam logic [2:0] CfgMaxTtl   = 3'd4;

  localparam logic [1:0] KindStart  = 2'd0;
  localparam logic [1:0] KindEntry  = 2'd1;
  localparam logic [1:0] KindTick   = 2'd2;
  localparam logic [1:0] KindLookup = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dest_addr;
    logic [CostW-1:0] adv_cost;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] fwd_hop;
    logic [CostW-1:0] route_cost;
    logic             changed;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] my_addr;
    logic [CostW-1:0] hop_cost;
    logic [CostW-1:0] max_cost;
    logic [CostW-1:0] inf_cost;
    logic [CostW-1:0] max_ttl;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;    // capture input item
    logic             single;  // do start/entry work on the item (none for a lookup)
    logic             age;     // aging step on entry idx
    logic             inval;   // invalidation step: neighbour idx against row jdx
    logic             absent;  // absent-route scan step on entry idx
    logic             report;  // build the result item
    logic [AddrW-1:0] idx;
    logic [AddrW-1:0] jdx;
  } cmd_t;

  function automatic logic in_range(input logic [AddrW-1:0] a);
    return (a != '0) && ({4'd0, a} <= 8'(NodeCount));
  endfunction

endpackage

### sv/dvrt_datapath.sv
// ---------------------------------------------------------------------------
// dvrt_datapath: route table storage and update logic
// Holds cost, hop, lifetime and neighbour flags; executes controller steps.
// ---------------------------------------------------------------------------
module dvrt_datapath import dvrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output out_item_t res_o
);

  logic [CostW-1:0] cost_q [Depth];
  logic [AddrW-1:0] hop_q  [Depth];
  logic [CostW-1:0] life_q [Depth];
  logic [Depth-1:0] nb_q, seen_q;
  logic             pend_q;
  logic             dead_q;
  in_item_t         it_q;
  out_item_t        res_q, res_d;

  logic [CostW:0]   cand;
  logic [CostW-1:0] lnext;
  logic             start_take;
  logic             dead;
  assign cand  = {1'b0, it_q.adv_cost} + {1'b0, cfg_i.hop_cost};
  assign lnext = (life_q[cmd_i.idx] != '0) ? life_q[cmd_i.idx] - 8'd1 : '0;
  assign start_take = in_range(it_q.src_addr) &&
                      (cost_q[it_q.src_addr] == cfg_i.inf_cost ||
                       it_q.src_addr == cfg_i.my_addr);
  // The dead-neighbour test is taken once per neighbour, on its first row step,
  // because clearing its own row would otherwise hide the later rows.
  assign dead = (cmd_i.jdx == 4'd1) ?
                (!nb_q[cmd_i.idx] && hop_q[cmd_i.idx] == cmd_i.idx &&
                 cmd_i.idx != cfg_i.my_addr) : dead_q;

  always_comb begin
    res_d = '0;
    if (it_q.kind == KindEntry && it_q.last) begin
      res_d.changed = pend_q;
    end else if (it_q.kind == KindLookup) begin
      if (in_range(it_q.dest_addr)) begin
        res_d.fwd_hop    = hop_q[it_q.dest_addr];
        res_d.route_cost = cost_q[it_q.dest_addr];
      end else begin
        res_d.route_cost = cfg_i.inf_cost;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        cost_q[i] <= 8'd255;
        hop_q[i]  <= '0;
        life_q[i] <= 8'd30;
      end
      nb_q   <= '0;
      seen_q <= '0;
      pend_q <= 1'b0;
      dead_q <= 1'b0;
      it_q   <= '0;
      res_q  <= '0;
    end else begin
      if (cmd_i.load) it_q <= item_i;
      if (cmd_i.single) begin
        case (it_q.kind)
          KindStart: begin
            seen_q <= '0;
            pend_q <= start_take;
            if (in_range(it_q.src_addr)) begin
              nb_q[it_q.src_addr] <= 1'b1;
              if (start_take) begin
                cost_q[it_q.src_addr] <= cfg_i.hop_cost;
                hop_q[it_q.src_addr]  <= it_q.src_addr;
                life_q[it_q.src_addr] <= cfg_i.max_ttl;
              end
            end
          end
          KindEntry: begin
            if (in_range(it_q.dest_addr) && in_range(it_q.src_addr) &&
                it_q.dest_addr != cfg_i.my_addr) begin
              seen_q[it_q.dest_addr] <= 1'b1;
              if (it_q.adv_cost != cfg_i.inf_cost) begin
                if (cand <= {1'b0, cfg_i.max_cost}) begin
                  if ({1'b0, cost_q[it_q.dest_addr]} > cand ||
                      cost_q[it_q.dest_addr] == cfg_i.inf_cost ||
                      life_q[it_q.dest_addr] == '0) begin
                    cost_q[it_q.dest_addr] <= cand[CostW-1:0];
                    hop_q[it_q.dest_addr]  <= it_q.src_addr;
                    life_q[it_q.dest_addr] <= cfg_i.max_ttl;
                    pend_q <= 1'b1;
                  end else if (cand > {1'b0, cost_q[it_q.dest_addr]} &&
                               hop_q[it_q.dest_addr] != it_q.src_addr) begin
                    pend_q <= 1'b1;
                  end
                end
              end else if (hop_q[it_q.dest_addr] == it_q.src_addr) begin
                pend_q <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.absent) begin
        if (cmd_i.idx != cfg_i.my_addr && !seen_q[cmd_i.idx] &&
            hop_q[cmd_i.idx] == it_q.src_addr)
          pend_q <= 1'b1;
      end
      if (cmd_i.age) begin
        life_q[cmd_i.idx] <= lnext;
        if (lnext == '0) nb_q[cmd_i.idx] <= 1'b0;
        if (cmd_i.idx == cfg_i.my_addr) cost_q[cmd_i.idx] <= '0;
      end
      if (cmd_i.inval) begin
        // Neighbour idx is dead and was its own next hop: drop row jdx through it.
        dead_q <= dead;
        if (dead && hop_q[cmd_i.jdx] == cmd_i.idx) begin
          cost_q[cmd_i.jdx] <= cfg_i.inf_cost;
          hop_q[cmd_i.jdx]  <= '0;
        end
      end
      if (cmd_i.report) begin
        res_q <= res_d;
        if (it_q.kind == KindEntry && it_q.last) begin
          pend_q <= 1'b0;
          seen_q <= '0;
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

### sv/dvrt_ctrl.sv
// ---------------------------------------------------------------------------
// dvrt_ctrl: sequencer of the distance-vector route table
// Steps each item through single work, table scans and result delivery.
// ---------------------------------------------------------------------------
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSingle = 3'd1;
  localparam logic [2:0] StAbsent = 3'd2;
  localparam logic [2:0] StAge    = 3'd3;
  localparam logic [2:0] StInval  = 3'd4;
  localparam logic [2:0] StReport = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0]       kind_q;
  logic             last_q;
  logic             idx_end, jdx_end;

  assign idx_end = ({4'd0, i_q} >= 8'(NodeCount)) || (i_q == '1);
  assign jdx_end = ({4'd0, j_q} >= 8'(NodeCount)) || (j_q == '1);
  assign in_ready_o  = (state_q == StIdle) || (state_q == StOut && out_ready_i);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    cmd_o   = '0;
    cmd_o.idx = i_q;
    cmd_o.jdx = j_q;
    unique case (state_q)
      StIdle, StOut: begin
        if (state_q == StOut && out_ready_i) state_d = StIdle;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          i_d = 4'd1;
          j_d = 4'd1;
          state_d = (kind_i == KindTick) ? StAge : StSingle;
        end
      end
      StSingle: begin
        cmd_o.single = 1'b1;
        state_d = (kind_q == KindEntry && last_q) ? StAbsent : StReport;
      end
      StAbsent: begin
        cmd_o.absent = 1'b1;
        i_d = i_q + 4'd1;
        if (idx_end) state_d = StReport;
      end
      StAge: begin
        cmd_o.age = 1'b1;
        i_d = i_q + 4'd1;
        if (idx_end) begin
          i_d = 4'd1;
          state_d = StInval;
        end
      end
      StInval: begin
        cmd_o.inval = 1'b1;
        j_d = j_q + 4'd1;
        if (jdx_end) begin
          j_d = 4'd1;
          i_d = i_q + 4'd1;
          if (idx_end) state_d = StReport;
        end
      end
      StReport: begin
        cmd_o.report = 1'b1;
        state_d = StOut;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= 4'd1;
      j_q     <= 4'd1;
      kind_q  <= KindStart;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (cmd_o.load) begin
        kind_q <= kind_i;
        last_q <= last_i;
      end
    end
  end

endmodule

### sv/distance_vector_route_table.sv
// ---------------------------------------------------------------------------
// distance_vector_route_table: distance-vector routing table update block
// Merges adverts, ages routes on ticks and answers next-hop lookups.
// ---------------------------------------------------------------------------
// Every item gives exactly one result item. Advert start and lookup go through
// the single work step and then the report step; an advert entry does the same,
// with a scan of absent routes over the 15 entries between them when it is the
// last entry. A tick runs one aging pass over the 15 entries, then one
// invalidation step for each pair of neighbour and route row, then the report step.
// The next item is taken in the cycle its predecessor's result is accepted.
module distance_vector_route_table import dvrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data_i,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data_o,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{my_addr: 4'd1, hop_cost: 8'd1, max_cost: 8'd16,
                 inf_cost: 8'd255, max_ttl: 8'd30};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMyAddr:   cfg_q.my_addr   <= cfg_data[AddrW-1:0];
        CfgLinkCost: cfg_q.hop_cost  <= cfg_data;
        CfgMaxCost:  cfg_q.max_cost  <= cfg_data;
        CfgInfCost:  cfg_q.inf_cost  <= cfg_data;
        CfgMaxTtl:   cfg_q.max_ttl   <= cfg_data;
        default: ;
      endcase
    end
  end

  dvrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .kind_i     (in_data_i.kind),
    .last_i     (in_data_i.last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .cmd_o      (cmd)
  );

  dvrt_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_i (cfg_q),
    .item_i(in_data_i),
    .cmd_i (cmd),
    .res_o (out_data_o)
  );

endmodule

### sv/dvrt_checker.sv
// ---------------------------------------------------------------------------
// dvrt_checker: port-level checks of the route table
// Observes handshakes and result values at the top-level ports.
// ---------------------------------------------------------------------------
module dvrt_checker import dvrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data_i,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_no_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in cycle after acceptance");

  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.changed |-> out_data_o.fwd_hop == '0)
    else $error("changed flag with a next hop");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("new item taken while result pending");

endmodule

bind distance_vector_route_table dvrt_checker u_chk (.*);

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the distance-vector route table
// Drives adverts, ticks and lookups with random idling on both sides and
// checks every result item against a predictor of the routing table.
// ---------------------------------------------------------------------------
class route_scoreboard;
  logic [3:0] my_addr;
  logic [7:0] hop_cost, max_cost, inf_cost, max_ttl;
  logic [7:0] cost_tab[16];
  logic [3:0] hop_tab[16];
  logic [7:0] life_tab[16];
  logic       nbr_tab[16];
  logic       pending;
  logic [15:0] seen;
  dvrt_pkg::out_item_t awaited[$];
  int errors;

  function new();
    my_addr = 1; hop_cost = 1; max_cost = 16; inf_cost = 255; max_ttl = 30;
    for (int i = 0; i < 16; i++) begin
      cost_tab[i] = 255; hop_tab[i] = 0; life_tab[i] = 30; nbr_tab[i] = 0;
    end
    pending = 0; seen = 0; errors = 0;
  endfunction

  function bit valid_addr(logic [3:0] a);
    return a >= 1 && a <= dvrt_pkg::NodeCount;
  endfunction

  function void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      dvrt_pkg::CfgMyAddr:   my_addr = val[3:0];
      dvrt_pkg::CfgLinkCost: hop_cost = val;
      dvrt_pkg::CfgMaxCost:  max_cost = val;
      dvrt_pkg::CfgInfCost:  inf_cost = val;
      dvrt_pkg::CfgMaxTtl:   max_ttl = val;
      default: ;
    endcase
  endfunction

  function void merge_entry(logic [3:0] src, logic [3:0] d, logic [7:0] adv);
    int cand;
    if (!valid_addr(d) || !valid_addr(src) || d == my_addr) return;
    seen[d] = 1;
    if (adv != inf_cost) begin
      cand = int'(adv) + int'(hop_cost);
      if (cand > max_cost) return;
      if (cost_tab[d] > cand || cost_tab[d] == inf_cost || life_tab[d] == 0) begin
        cost_tab[d] = cand[7:0]; hop_tab[d] = src; life_tab[d] = max_ttl; pending = 1;
      end else if (cand > cost_tab[d] && hop_tab[d] != src) begin
        pending = 1;
      end
    end else if (hop_tab[d] == src) begin
      pending = 1;
    end
  endfunction

  function void age_table();
    for (int i = 1; i <= 15; i++) begin
      if (life_tab[i] > 0) life_tab[i]--;
      if (life_tab[i] == 0) nbr_tab[i] = 0;
      if (i == my_addr) cost_tab[i] = 0;
    end
    for (int i = 1; i <= 15; i++)
      if (!nbr_tab[i] && hop_tab[i] == i && i != my_addr)
        for (int j = 1; j <= 15; j++)
          if (hop_tab[j] == i) begin
            cost_tab[j] = inf_cost; hop_tab[j] = 0;
          end
  endfunction

  function void note_item(dvrt_pkg::in_item_t it);
    dvrt_pkg::out_item_t r;
    r = '0;
    case (it.kind)
      dvrt_pkg::KindStart: begin
        pending = 0; seen = 0;
        if (valid_addr(it.src_addr)) begin
          nbr_tab[it.src_addr] = 1;
          if (cost_tab[it.src_addr] == inf_cost || it.src_addr == my_addr) begin
            cost_tab[it.src_addr] = hop_cost; hop_tab[it.src_addr] = it.src_addr;
            life_tab[it.src_addr] = max_ttl; pending = 1;
          end
        end
      end
      dvrt_pkg::KindEntry: begin
        merge_entry(it.src_addr, it.dest_addr, it.adv_cost);
        if (it.last) begin
          for (int d = 1; d <= 15; d++)
            if (d != my_addr && !seen[d] && hop_tab[d] == it.src_addr) pending = 1;
          r.changed = pending; pending = 0; seen = 0;
        end
      end
      dvrt_pkg::KindTick: age_table();
      default: begin
        if (valid_addr(it.dest_addr)) begin
          r.fwd_hop = hop_tab[it.dest_addr]; r.route_cost = cost_tab[it.dest_addr];
        end else begin
          r.route_cost = inf_cost;
        end
      end
    endcase
    awaited = {awaited, r};
  endfunction

  function void check_result(dvrt_pkg::out_item_t got);
    dvrt_pkg::out_item_t exp;
    if (awaited.size() == 0) begin
      $error("unexpected result item %h", got); errors++; return;
    end
    exp = awaited.pop_front();
    if (got.fwd_hop !== exp.fwd_hop) begin
      $error("fwd_hop: expected %0d, got %0d", exp.fwd_hop, got.fwd_hop); errors++;
    end
    if (got.route_cost !== exp.route_cost) begin
      $error("route_cost: expected %0d, got %0d", exp.route_cost, got.route_cost); errors++;
    end
    if (got.changed !== exp.changed) begin
      $error("changed: expected %0d, got %0d", exp.changed, got.changed); errors++;
    end
  endfunction
endclass

module tb_top;
  import dvrt_pkg::*;

  localparam int ItemW = $bits(in_item_t);

  logic clk_i = 0, rst_ni = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t in_data_i = '0;
  out_item_t out_data_o;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  int send_idle = 0, recv_stall = 0;
  bit hold_recv = 0;
  bit done = 0;
  longint cycles = 0;
  route_scoreboard routes = new();

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  distance_vector_route_table DUT (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off under control of the stimulus.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) routes.check_result(out_data_o);
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall);
    end
  end

  // Valid stays high after an acceptance so that items can follow back to back;
  // it drops only when the sender idles or pauses.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid <= 1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    routes.note_item(it);
  endtask

  function automatic in_item_t make_item(logic [1:0] k, logic [3:0] s, logic [3:0] d,
                                         logic [7:0] c, logic l);
    in_item_t it;
    it.kind = k; it.src_addr = s; it.dest_addr = d; it.adv_cost = c; it.last = l;
    return it;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (routes.awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 0;
    routes.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // An advert: mostly a start, then a few entries with the last one marked; the source is sometimes out of range.
  task automatic send_advert();
    logic [3:0] s;
    int n;
    s = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 6));
    n = $urandom_range(1, 6);
    if ($urandom_range(9) != 0) send_item(make_item(KindStart, s, 0, 0, 0));
    for (int i = 0; i < n; i++)
      send_item(make_item(KindEntry, s, 4'($urandom_range(15)),
                          ($urandom_range(3) == 0) ? routes.inf_cost : 8'($urandom),
                          i == n - 1));
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; ) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_advert(); i += 4;
      end else if (r < 65) begin
        send_item(make_item(KindTick, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom)));
        i++;
      end else if (r < 90) begin
        send_item(make_item(KindLookup, 4'($urandom), 4'($urandom), 8'($urandom),
                            1'($urandom)));
        i++;
      end else begin
        send_item(in_item_t'(ItemW'($urandom))); i++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes of the fields, every kind, and the corner cases.
    send_item(make_item(KindLookup, 0, 0, 0, 0));
    send_item(make_item(KindLookup, 15, 15, 255, 1));
    send_item(make_item(KindEntry, 2, 3, 4, 1));          // entry without start
    send_item(make_item(KindStart, 0, 0, 0, 0));          // source out of range
    send_item(make_item(KindStart, 1, 0, 0, 0));          // source is own address
    send_item(make_item(KindStart, 2, 0, 0, 0));
    send_item(make_item(KindEntry, 2, 1, 3, 0));          // entry for own address
    send_item(make_item(KindEntry, 2, 5, 3, 0));
    send_item(make_item(KindEntry, 2, 6, 255, 0));        // infinite advert
    send_item(make_item(KindEntry, 2, 7, 200, 0));        // over the cost barrier
    send_item(make_item(KindEntry, 0, 7, 2, 0));
    send_item(make_item(KindEntry, 2, 15, 0, 1));
    send_item(make_item(KindStart, 3, 0, 0, 0));
    send_item(make_item(KindEntry, 3, 5, 9, 0));          // worse, other neighbour
    send_item(make_item(KindEntry, 3, 0, 1, 1));
    send_item(make_item(KindStart, 2, 0, 0, 0));
    send_item(make_item(KindEntry, 2, 4, 1, 1));          // absent route through sender
    send_item(make_item(KindTick, 0, 0, 0, 0));
    send_item(make_item(KindLookup, 0, 5, 0, 0));
    send_item(make_item(KindLookup, 0, 1, 0, 0));
    drain();

    // Low lifetime so routes expire, then the other extremes.
    write_reg(CfgMaxTtl, 1);
    write_reg(CfgMyAddr, 15);
    write_reg(CfgLinkCost, 255);
    write_reg(CfgMaxCost, 255);
    write_reg(CfgInfCost, 0);
    random_phase(150);
    drain();

    write_reg(CfgMyAddr, 0);
    write_reg(CfgLinkCost, 1);
    write_reg(CfgMaxCost, 0);
    write_reg(CfgInfCost, 255);
    write_reg(CfgMaxTtl, 255);
    random_phase(100);
    drain();

    write_reg(CfgMyAddr, 3);
    write_reg(CfgLinkCost, 2);
    write_reg(CfgMaxCost, 40);
    write_reg(CfgMaxTtl, 4);
    write_reg(CfgInfCost, 64);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 3 ? 16 : 68) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 16 : 68) : 0;
      random_phase(300);
    end
    send_idle = 0; recv_stall = 0;

    // The receiver holds off while items keep coming, until the input stalls.
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
      random_phase(40);
    join
    drain();
    write_reg(CfgMaxTtl, 30);
    write_reg(CfgInfCost, 255);
    write_reg(CfgMaxCost, 16);
    write_reg(CfgLinkCost, 1);
    write_reg(CfgMyAddr, 1);
    random_phase(200);
    drain();

    if (routes.errors == 0 && routes.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
sv/dvrt_pkg.sv
sv/dvrt_datapath.sv
sv/dvrt_ctrl.sv
sv/distance_vector_route_table.sv
sv/dvrt_checker.sv
dv/tb_top.sv
